// ===== rtl/core/touch_point_event_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// touch_point_event_tracker_macros
// Assertion macros used by the checker file of the touch tracker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_POINT_EVENT_TRACKER_MACROS_SVH
`define TOUCH_POINT_EVENT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TPET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define TPET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tpet_pkg.sv =====
// ----------------------------------------------------------------------------
// tpet_pkg
// Types and constants of the touch point event tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tpet_pkg;

   // Coordinate, raw, byte, nibble and register index widths
   localparam int COORD_W = 13;
   localparam int RAW_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int NIB_W   = 4;
   localparam int CSR_IDX_W = 3;

   // Register reset values
   localparam logic [COORD_W-1:0] DISPLAY_WIDTH_RST  = 13'd320;
   localparam logic [COORD_W-1:0] DISPLAY_HEIGHT_RST = 13'd240;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SWAP_AXES         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIRROR_HORIZONTAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIRROR_VERTICAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DISPLAY_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DISPLAY_HEIGHT    = 3'd4;

   // Event kinds
   typedef enum logic [1:0] {
      ACT_PRESS   = 2'd0,
      ACT_CHANGE  = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   // Orientation settings
   typedef struct packed {
      logic               swap_axes;
      logic               mirror_horizontal;
      logic               mirror_vertical;
      logic [COORD_W-1:0] display_width;
      logic [COORD_W-1:0] display_height;
   } orient_cfg_type;

   // One poll as held in the input register
   typedef struct packed {
      logic              device_attached;
      logic              read_ok;
      logic [BYTE_W-1:0] status_byte;
      logic [BYTE_W-1:0] x_high_byte;
      logic [BYTE_W-1:0] x_low_byte;
      logic [BYTE_W-1:0] y_high_byte;
      logic [BYTE_W-1:0] y_low_byte;
   } poll_type;

endpackage

`default_nettype wire

// ===== rtl/core/tpet_channels.sv =====
// ----------------------------------------------------------------------------
// tpet_channels
// Valid/ready channels of the tracker: poll requests, events and registers.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpet_req_if import tpet_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              device_attached;
   logic              read_ok;
   logic [BYTE_W-1:0] status_byte;
   logic [BYTE_W-1:0] x_high_byte;
   logic [BYTE_W-1:0] x_low_byte;
   logic [BYTE_W-1:0] y_high_byte;
   logic [BYTE_W-1:0] y_low_byte;

   modport source (output valid, device_attached, read_ok, status_byte,
                   x_high_byte, x_low_byte, y_high_byte, y_low_byte,
                   input ready);
   modport sink   (input valid, device_attached, read_ok, status_byte,
                   x_high_byte, x_low_byte, y_high_byte, y_low_byte,
                   output ready);
endinterface

interface tpet_rsp_if import tpet_pkg::*; ();
   logic                      valid;
   logic                      ready;
   action_type                action;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;

   modport source (output valid, action, pos_x, pos_y, input ready);
   modport sink   (input valid, action, pos_x, pos_y, output ready);
endinterface

interface tpet_csr_if import tpet_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COORD_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tpet_orient.sv =====
// ----------------------------------------------------------------------------
// tpet_orient
// Decode the 12-bit point, then swap and mirror it against the display size.
// ----------------------------------------------------------------------------
`default_nettype none

module tpet_orient import tpet_pkg::*; (
   input  wire orient_cfg_type     cfg,
   input  wire logic [BYTE_W-1:0]  x_high_byte,
   input  wire logic [BYTE_W-1:0]  x_low_byte,
   input  wire logic [BYTE_W-1:0]  y_high_byte,
   input  wire logic [BYTE_W-1:0]  y_low_byte,
   output logic      [COORD_W-1:0] pos_x,
   output logic      [COORD_W-1:0] pos_y
);

   logic [COORD_W-1:0] raw_x;
   logic [COORD_W-1:0] raw_y;
   logic [COORD_W-1:0] swp_x;
   logic [COORD_W-1:0] swp_y;

   // Drop the high nibbles of the high point bytes
   assign raw_x = {1'b0, x_high_byte[NIB_W-1:0], x_low_byte};
   assign raw_y = {1'b0, y_high_byte[NIB_W-1:0], y_low_byte};

   // Exchange the axes first
   assign swp_x = cfg.swap_axes ? raw_y : raw_x;
   assign swp_y = cfg.swap_axes ? raw_x : raw_y;

   // Mirror modulo 2^13, no clamping
   assign pos_x = cfg.mirror_horizontal ?
                  cfg.display_width - COORD_W'(1) - swp_x : swp_x;
   assign pos_y = cfg.mirror_vertical ?
                  cfg.display_height - COORD_W'(1) - swp_y : swp_y;

endmodule

`default_nettype wire

// ===== rtl/core/touch_point_event_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_point_event_tracker
// Path: an accepted request loads the input register, then the result register holds the event.
// Throughput: one request per cycle while events are taken; the result register frees when empty or taken.
// Reset: synchronous; clears pipeline valids, touch state, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_point_event_tracker import tpet_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   tpet_req_if.sink   req,
   tpet_rsp_if.source rsp,
   tpet_csr_if.sink   csr
);

   orient_cfg_type            cfg_ff;
   orient_cfg_type            cfg_in;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   poll_type                  s1_poll_ff;
   poll_type                  s1_poll_in;

   logic                      was_pressed_ff;
   logic                      was_pressed_in;
   logic [COORD_W-1:0]        last_x_ff;
   logic [COORD_W-1:0]        last_x_in;
   logic [COORD_W-1:0]        last_y_ff;
   logic [COORD_W-1:0]        last_y_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   action_type                rsp_action_ff;
   action_type                rsp_action_in;
   logic signed [COORD_W-1:0] rsp_x_ff;
   logic signed [COORD_W-1:0] rsp_x_in;
   logic signed [COORD_W-1:0] rsp_y_ff;
   logic signed [COORD_W-1:0] rsp_y_in;

   logic                      advance;
   logic                      take;
   logic                      pressed;
   logic                      emit;
   action_type                act;
   logic [COORD_W-1:0]        ori_x;
   logic [COORD_W-1:0]        ori_y;

   // Handshake: the result slot frees when empty or taken
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign take      = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;
   assign csr.ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_SWAP_AXES:         cfg_in.swap_axes         = csr.data[0];
            REG_MIRROR_HORIZONTAL: cfg_in.mirror_horizontal = csr.data[0];
            REG_MIRROR_VERTICAL:   cfg_in.mirror_vertical   = csr.data[0];
            REG_DISPLAY_WIDTH:     cfg_in.display_width     = csr.data;
            REG_DISPLAY_HEIGHT:    cfg_in.display_height    = csr.data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // Input register: load on accept, drain when taken
   always_comb begin
      s1_poll_in  = s1_poll_ff;
      s1_valid_in = s1_valid_ff && !take;
      if (req.valid && req.ready) begin
         s1_valid_in = 1'b1;
         s1_poll_in  = '{device_attached: req.device_attached,
                         read_ok:         req.read_ok,
                         status_byte:     req.status_byte,
                         x_high_byte:     req.x_high_byte,
                         x_low_byte:      req.x_low_byte,
                         y_high_byte:     req.y_high_byte,
                         y_low_byte:      req.y_low_byte};
      end
   end

   tpet_orient u_orient (
      .cfg         (cfg_ff),
      .x_high_byte (s1_poll_ff.x_high_byte),
      .x_low_byte  (s1_poll_ff.x_low_byte),
      .y_high_byte (s1_poll_ff.y_high_byte),
      .y_low_byte  (s1_poll_ff.y_low_byte),
      .pos_x       (ori_x),
      .pos_y       (ori_y)
   );

   // Classify the poll against the kept touch state
   assign pressed = s1_poll_ff.read_ok && (s1_poll_ff.status_byte[NIB_W-1:0] != '0);

   always_comb begin
      emit = 1'b0;
      act  = ACT_PRESS;
      if (s1_poll_ff.device_attached) begin
         if (pressed && !was_pressed_ff) begin
            emit = 1'b1;
            act  = ACT_PRESS;
         end else if (pressed && ((ori_x != last_x_ff) || (ori_y != last_y_ff))) begin
            emit = 1'b1;
            act  = ACT_CHANGE;
         end else if (!pressed && was_pressed_ff) begin
            emit = 1'b1;
            act  = ACT_RELEASE;
         end
      end
   end

   // Advance touch state and the result register
   always_comb begin
      was_pressed_in = was_pressed_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_action_in  = rsp_action_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      if (take && s1_poll_ff.device_attached) begin
         was_pressed_in = pressed;
         if (pressed) begin
            last_x_in = ori_x;
            last_y_in = ori_y;
         end
      end
      if (take && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = act;
         rsp_x_in      = (act == ACT_RELEASE) ? signed'(last_x_ff) : signed'(ori_x);
         rsp_y_in      = (act == ACT_RELEASE) ? signed'(last_y_ff) : signed'(ori_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '{swap_axes:         1'b0,
                             mirror_horizontal: 1'b0,
                             mirror_vertical:   1'b0,
                             display_width:     DISPLAY_WIDTH_RST,
                             display_height:    DISPLAY_HEIGHT_RST};
         s1_valid_ff    <= 1'b0;
         was_pressed_ff <= 1'b0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         s1_valid_ff    <= s1_valid_in;
         was_pressed_ff <= was_pressed_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s1_poll_ff    <= s1_poll_in;
      rsp_action_ff <= rsp_action_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.action = rsp_action_ff;
   assign rsp.pos_x  = rsp_x_ff;
   assign rsp.pos_y  = rsp_y_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tpet_checker.sv =====
// ----------------------------------------------------------------------------
// tpet_checker
// Port-level checks of the event stream: stall hold, ordering of press, change, release, and event positions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_point_event_tracker_macros.svh"

module tpet_checker import tpet_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire action_type                rsp_action,
   input wire logic signed [COORD_W-1:0] rsp_pos_x,
   input wire logic signed [COORD_W-1:0] rsp_pos_y
);

   logic               held_ff;
   logic               held_in;
   logic [COORD_W-1:0] seen_x_ff;
   logic [COORD_W-1:0] seen_x_in;
   logic [COORD_W-1:0] seen_y_ff;
   logic [COORD_W-1:0] seen_y_in;
   logic               acc;
   logic               same_pos;

   assign acc      = rsp_valid && rsp_ready;
   assign same_pos = (rsp_pos_x == signed'(seen_x_ff)) && (rsp_pos_y == signed'(seen_y_ff));

   // Track the touch as seen on the event stream
   always_comb begin
      held_in   = held_ff;
      seen_x_in = seen_x_ff;
      seen_y_in = seen_y_ff;
      if (acc) begin
         held_in = (rsp_action != ACT_RELEASE);
         if (rsp_action != ACT_RELEASE) begin
            seen_x_in = unsigned'(rsp_pos_x);
            seen_y_in = unsigned'(rsp_pos_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         seen_x_ff <= '0;
         seen_y_ff <= '0;
      end else begin
         held_ff   <= held_in;
         seen_x_ff <= seen_x_in;
         seen_y_ff <= seen_y_in;
      end
   end

   `TPET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_action) && $stable(rsp_pos_x) && $stable(rsp_pos_y),
      "stalled event changed")
   `TPET_ASSERT_NOW(a_press_when_free, clock, reset, acc && (rsp_action == ACT_PRESS),
      !held_ff, "press while already held")
   `TPET_ASSERT_NOW(a_follow_press, clock, reset,
      acc && ((rsp_action == ACT_CHANGE) || (rsp_action == ACT_RELEASE)),
      held_ff, "change or release without a press")
   `TPET_ASSERT_NOW(a_release_pos, clock, reset, acc && (rsp_action == ACT_RELEASE),
      same_pos, "release not at the last point")
   `TPET_ASSERT_NOW(a_change_moves, clock, reset, acc && (rsp_action == ACT_CHANGE),
      !same_pos, "change without movement")

endmodule

bind touch_point_event_tracker tpet_checker u_tpet_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_action (rsp.action),
   .rsp_pos_x  (rsp.pos_x),
   .rsp_pos_y  (rsp.pos_y)
);

`default_nettype wire
